/* hdl/gpg_pkg.sv */
// ----------------------------------------------------------------------------
// gpg_pkg
// Shared constants and types for the polar-method Gaussian generator.
// ----------------------------------------------------------------------------
package gpg_pkg;

  localparam int UNIFORM_BITS_DEF = 32;

  localparam int LOG_FRAC_BITS = 26;
  localparam int DIV_STEPS     = 34;
  localparam int SQRT_STEPS    = 29;

  // ln(2) in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STD  = 2'd1;

  localparam logic [31:0] MEAN_RST = 32'h0000_0000;
  localparam logic [31:0] STD_RST  = 32'h0001_0000;

  typedef struct packed {
    logic        valid;
    logic [31:0] sample;
    logic        from_spare;
  } result_t;

endpackage

/* hdl/gpg_outreg.sv */
// ----------------------------------------------------------------------------
// gpg_outreg
// Output register: holds one finished beat until the sink takes it.
// ----------------------------------------------------------------------------
module gpg_outreg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gpg_pkg::result_t     res,
  output logic                 push_ok,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_sample,
  output logic                 out_from_spare
);

  logic        ov_r, ov_nxt;
  logic [31:0] sample_r;
  logic        spare_r;

  assign push_ok = ~ov_r | ~out_stall;

  always_comb begin
    ov_nxt = ov_r;
    if (res.valid && push_ok) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    if (res.valid && push_ok) begin
      sample_r <= res.sample;
      spare_r  <= res.from_spare;
    end
  end

  assign out_valid      = ov_r;
  assign out_sample     = sample_r;
  assign out_from_spare = spare_r;

endmodule

/* hdl/gpg_core.sv */
// ----------------------------------------------------------------------------
// gpg_core
// Sequencer around one shared 32x32 multiplier and one shared
// compare-subtract: squares, normalize, log2, ln scale, divide, sqrt, scale.
// ----------------------------------------------------------------------------
module gpg_core #(
  parameter int UNIFORM_BITS = gpg_pkg::UNIFORM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_uniform_u,
  input  logic signed [31:0]   in_uniform_v,
  input  logic signed [31:0]   mean_value,
  input  logic [31:0]          std_dev,
  input  logic                 push_ok,
  output gpg_pkg::result_t     res
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SQU   = 13'b0000000000010,
    S_SQV   = 13'b0000000000100,
    S_NORM  = 13'b0000000001000,
    S_LOG   = 13'b0000000010000,
    S_TSUB  = 13'b0000000100000,
    S_LNW   = 13'b0000001000000,
    S_DIV   = 13'b0000010000000,
    S_SQRT  = 13'b0000100000000,
    S_MU    = 13'b0001000000000,
    S_MV    = 13'b0010000000000,
    S_SCALE = 13'b0100000000000,
    S_SUM   = 13'b1000000000000
  } state_t;

  localparam logic [31:0] UMASK = ~((32'd1 << (32 - UNIFORM_BITS)) - 32'd1);
  localparam logic [5:0] LOG_LAST  = 6'(gpg_pkg::LOG_FRAC_BITS - 1);
  localparam logic [5:0] DIV_LAST  = 6'(gpg_pkg::DIV_STEPS - 1);
  localparam logic [5:0] SQRT_LAST = 6'(gpg_pkg::SQRT_STEPS - 1);
  localparam logic signed [41:0] SAT_HI = 42'sd2147483647;
  localparam logic signed [41:0] SAT_LO = -42'sd2147483648;

  state_t      state_r, state_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] spare_r, spare_nxt;
  logic        u_neg_r, u_neg_nxt, v_neg_r, v_neg_nxt;
  logic [31:0] au_r, au_nxt, av_r, av_nxt;
  logic [63:0] s_r, s_nxt;
  logic [4:0]  k_r, k_nxt;
  logic [5:0]  e_r, e_nxt;
  logic [31:0] y_r, y_nxt;
  logic [31:0] d_r, d_nxt;
  logic [25:0] frac_r, frac_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] t_r, t_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [1:0]  wlo_r, wlo_nxt;
  logic [33:0] q_r, q_nxt;
  logic [57:0] sqx_r, sqx_nxt;
  logic [28:0] root_r, root_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [39:0] p_r, p_nxt;
  logic        fsp_r, fsp_nxt;

  logic [31:0] u_m, v_m;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [33:0] sub_a, sub_b;
  logic [34:0] sub_d;
  logic        ge;
  logic [63:0] s_sum;
  logic [32:0] yy;
  logic [31:0] mv;
  logic [41:0] pe, sp;
  logic signed [41:0] r_s;
  logic [31:0] sat;

  assign u_m = in_uniform_u & UMASK;
  assign v_m = in_uniform_v & UMASK;
  assign in_stall = (state_r != S_IDLE);

  // shared multiplier
  always_comb begin
    case (state_r)
      S_SQU:   begin mul_a = au_r;    mul_b = au_r; end
      S_SQV:   begin mul_a = av_r;    mul_b = av_r; end
      S_LOG:   begin mul_a = y_r;     mul_b = y_r; end
      S_LNW:   begin mul_a = t_r;     mul_b = gpg_pkg::LN2_Q32; end
      S_MU:    begin mul_a = au_r;    mul_b = {3'd0, root_r}; end
      S_MV:    begin mul_a = av_r;    mul_b = {3'd0, root_r}; end
      S_SCALE: begin mul_a = std_dev; mul_b = mag_r; end
      default: begin mul_a = 32'd0;   mul_b = 32'd0; end
    endcase
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // shared compare-subtract: restoring divide and digit-by-digit sqrt
  always_comb begin
    if (state_r == S_SQRT) begin
      sub_a = {1'b0, rem_r[30:0], sqx_r[57:56]};
      sub_b = {3'd0, root_r, 2'b01};
    end else begin
      sub_a = {1'b0, rem_r[31:0], wlo_r[1]};
      sub_b = {2'd0, d_r};
    end
  end
  assign sub_d = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge    = ~sub_d[34];

  assign s_sum = s_r + mul_p;
  assign yy    = mul_p[63:31];
  assign mv    = mul_p[62:31];

  // final scale: +/- p plus mean, saturated
  assign pe  = {2'd0, p_r};
  assign sp  = neg_r ? (42'd0 - pe) : pe;
  assign r_s = $signed(sp + {{10{mean_value[31]}}, mean_value});
  always_comb begin
    if (r_s > SAT_HI) begin
      sat = 32'h7FFF_FFFF;
    end else if (r_s < SAT_LO) begin
      sat = 32'h8000_0000;
    end else begin
      sat = r_s[31:0];
    end
  end

  assign res.valid      = (state_r == S_SUM);
  assign res.sample     = sat;
  assign res.from_spare = fsp_r;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    spare_nxt = spare_r;
    u_neg_nxt = u_neg_r;
    v_neg_nxt = v_neg_r;
    au_nxt    = au_r;
    av_nxt    = av_r;
    s_nxt     = s_r;
    k_nxt     = k_r;
    e_nxt     = e_r;
    y_nxt     = y_r;
    d_nxt     = d_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    t_nxt     = t_r;
    rem_nxt   = rem_r;
    wlo_nxt   = wlo_r;
    q_nxt     = q_r;
    sqx_nxt   = sqx_r;
    root_nxt  = root_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    p_nxt     = p_r;
    fsp_nxt   = fsp_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (pend_r) begin
            pend_nxt  = 1'b0;
            neg_nxt   = spare_r[31];
            mag_nxt   = spare_r[31] ? (32'd0 - spare_r) : spare_r;
            fsp_nxt   = 1'b1;
            state_nxt = S_SCALE;
          end else begin
            u_neg_nxt = u_m[31];
            v_neg_nxt = v_m[31];
            au_nxt    = u_m[31] ? (32'd0 - u_m) : u_m;
            av_nxt    = v_m[31] ? (32'd0 - v_m) : v_m;
            k_nxt     = 5'd0;
            state_nxt = S_SQU;
          end
        end
      end
      S_SQU: begin
        s_nxt     = mul_p;
        state_nxt = S_SQV;
      end
      S_SQV: begin
        s_nxt = s_sum;
        if (s_sum == 64'd0 || s_sum[63:62] != 2'b00) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (s_r[61:60] == 2'b00) begin
          if (s_r[61:54] == 8'd0) begin
            s_nxt  = {s_r[55:0], 8'd0};
            k_nxt  = k_r + 5'd4;
            au_nxt = {au_r[27:0], 4'd0};
            av_nxt = {av_r[27:0], 4'd0};
          end else begin
            s_nxt  = {s_r[61:0], 2'd0};
            k_nxt  = k_r + 5'd1;
            au_nxt = {au_r[30:0], 1'b0};
            av_nxt = {av_r[30:0], 1'b0};
          end
        end else begin
          if (s_r[61]) begin
            e_nxt = {k_r, 1'b1};
            y_nxt = s_r[61:30];
          end else begin
            e_nxt = {k_r, 1'b0} + 6'd2;
            y_nxt = s_r[60:29];
          end
          d_nxt     = s_r[61:30];
          frac_nxt  = 26'd0;
          cnt_nxt   = 6'd0;
          state_nxt = S_LOG;
        end
      end
      S_LOG: begin
        // square; a carry past 2.0 yields a 1 bit and renormalizes
        y_nxt    = yy[32] ? yy[32:1] : yy[31:0];
        frac_nxt = {frac_r[24:0], yy[32]};
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == LOG_LAST) begin
          state_nxt = S_TSUB;
        end
      end
      S_TSUB: begin
        t_nxt     = {e_r, 26'd0} - {6'd0, frac_r};
        state_nxt = S_LNW;
      end
      S_LNW: begin
        // dividend is hi(W) << 32; start with its bits above the quotient
        rem_nxt   = {3'd0, mul_p[63:34]};
        wlo_nxt   = mul_p[33:32];
        q_nxt     = 34'd0;
        cnt_nxt   = 6'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? sub_d[32:0] : sub_a[32:0];
        q_nxt   = {q_r[32:0], ge};
        wlo_nxt = {wlo_r[0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          sqx_nxt   = {1'b0, q_r[32:0], ge, 23'd0};
          rem_nxt   = 33'd0;
          root_nxt  = 29'd0;
          cnt_nxt   = 6'd0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        rem_nxt  = ge ? sub_d[32:0] : sub_a[32:0];
        root_nxt = {root_r[27:0], ge};
        sqx_nxt  = {sqx_r[55:0], 2'b00};
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == SQRT_LAST) begin
          state_nxt = S_MU;
        end
      end
      S_MU: begin
        mag_nxt   = mul_p[62:31];
        neg_nxt   = u_neg_r;
        state_nxt = S_MV;
      end
      S_MV: begin
        spare_nxt = v_neg_r ? (32'd0 - mv) : mv;
        pend_nxt  = 1'b1;
        fsp_nxt   = 1'b0;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        p_nxt     = mul_p[63:24];
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (push_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      spare_r <= 32'd0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      spare_r <= spare_nxt;
    end
    u_neg_r <= u_neg_nxt;
    v_neg_r <= v_neg_nxt;
    au_r    <= au_nxt;
    av_r    <= av_nxt;
    s_r     <= s_nxt;
    k_r     <= k_nxt;
    e_r     <= e_nxt;
    y_r     <= y_nxt;
    d_r     <= d_nxt;
    frac_r  <= frac_nxt;
    cnt_r   <= cnt_nxt;
    t_r     <= t_nxt;
    rem_r   <= rem_nxt;
    wlo_r   <= wlo_nxt;
    q_r     <= q_nxt;
    sqx_r   <= sqx_nxt;
    root_r  <= root_nxt;
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
    p_r     <= p_nxt;
    fsp_r   <= fsp_nxt;
  end

  a_spare_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && pend_r) |=> (state_r == S_SCALE && !pend_r))
    else $error("spare beat did not go straight to scaling");

  a_pend_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pend_r) |-> $past(state_r) == S_MV)
    else $error("spare set outside the second product step");

  a_log_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOG) |-> y_r[31])
    else $error("log operand left [1,2)");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < {1'b0, d_r}))
    else $error("divide remainder not below divisor");

endmodule

/* hdl/gaussian_polar_generator.sv */
// ----------------------------------------------------------------------------
// gaussian_polar_generator
// Marsaglia polar normal generator in fixed point (Q1.31 in, Q16.16 out).
//
//   channel | ports                             | handshake
//   --------+-----------------------------------+----------------------
//   input   | in_uniform_u, in_uniform_v        | in_valid / in_stall
//   result  | out_sample, out_from_spare        | out_valid / out_stall
//   config  | cfg_index, cfg_data               | cfg_valid / cfg_ready
//
// A beat with a spare pending goes from accept straight to scale and sum,
// then to the output register. A fresh pair runs through normalize, log2,
// divide and sqrt on the shared multiplier and subtractor; a rejected pair
// returns the block to idle after the squares. in_stall is high while
// a beat is in work. One finished beat may wait in the output register while
// the next pair is taken. Reset clears the spare and restores mean and std.
// ----------------------------------------------------------------------------
module gaussian_polar_generator #(
  parameter int UNIFORM_BITS = gpg_pkg::UNIFORM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [31:0]              in_uniform_u,
  input  logic signed [31:0]              in_uniform_v,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              out_sample,
  output logic                            out_from_spare,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);

  logic [31:0]      mean_r;
  logic [31:0]      std_r;
  gpg_pkg::result_t res;
  logic             push_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= gpg_pkg::MEAN_RST;
      std_r  <= gpg_pkg::STD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gpg_pkg::REG_MEAN: mean_r <= cfg_data;
        gpg_pkg::REG_STD:  std_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gpg_core #(
    .UNIFORM_BITS(UNIFORM_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_uniform_u (in_uniform_u),
    .in_uniform_v (in_uniform_v),
    .mean_value   ($signed(mean_r)),
    .std_dev      (std_r),
    .push_ok      (push_ok),
    .res          (res)
  );

  gpg_outreg u_outreg (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .push_ok        (push_ok),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample),
    .out_from_spare (out_from_spare)
  );

endmodule

/* dv/tb_gaussian_polar_generator.sv */
// ----------------------------------------------------------------------------
// tb_gaussian_polar_generator
// Self-checking bench: drives uniform pairs, predicts each normal sample in
// fixed point and compares every result beat against the predicted queue.
// ----------------------------------------------------------------------------
module tb_gaussian_polar_generator;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] sample;
    logic        from_spare;
  } sample_t;

  // index with no register behind it
  localparam logic [gpg_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [31:0]            in_uniform_u = '0;
  logic signed [31:0]            in_uniform_v = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [31:0]            out_sample;
  logic                          out_from_spare;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [gpg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                   cfg_data = '0;

  gaussian_polar_generator u_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [63:0] mean_q;
  logic [63:0]        std_q;
  logic               spare_ok;
  logic [31:0]        spare_z;

  sample_t     pending_q[$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_seen = 0;
  int          n_spare = 0;
  int          n_sat = 0;
  bit          quiet = 1'b0;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r = 0;
    logic [63:0] b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] scale_sample(logic signed [63:0] z);
    logic [63:0]        mag;
    logic signed [63:0] r;
    mag = z < 0 ? -z : z;
    r = $signed((std_q * mag) >> 24);
    if (z < 0) r = -r;
    r += mean_q;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // returns 1 when the pair yields a sample
  function automatic bit polar_predict(logic [31:0] ui, logic [31:0] vi,
                                       output sample_t res);
    logic signed [63:0] u, v, zu, zv;
    logic [63:0] au, av, s, y, fr, e, t, w, q, h, mu, mv;
    int k;
    if (spare_ok) begin
      spare_ok = 0;
      res.sample = scale_sample($signed({{32{spare_z[31]}}, spare_z}));
      res.from_spare = 1;
      return 1;
    end
    u = $signed(ui);
    v = $signed(vi);
    au = u < 0 ? -u : u;
    av = v < 0 ? -v : v;
    s = au * au + av * av;
    if (s == 0 || s >= (64'd1 << 62)) return 0;
    k = 0;
    while (s < (64'd1 << 60)) begin
      s <<= 2;
      k++;
    end
    if (s >= (64'd1 << 61)) begin
      e = 1 + 2 * k;
      y = s >> 30;
    end else begin
      e = 2 + 2 * k;
      y = s >> 29;
    end
    fr = 0;
    for (int i = 0; i < gpg_pkg::LOG_FRAC_BITS; i++) begin
      y = (y * y) >> 31;
      fr <<= 1;
      if (y >= (64'd1 << 32)) begin
        y >>= 1;
        fr |= 1;
      end
    end
    t = (e << gpg_pkg::LOG_FRAC_BITS) - fr;
    w = t * {32'd0, gpg_pkg::LN2_Q32};
    q = ((w >> 32) << 32) / (s >> 30);
    h = int_sqrt(q << 23);
    mu = ((au << k) * h) >> 31;
    mv = ((av << k) * h) >> 31;
    zu = u < 0 ? -mu : mu;
    zv = v < 0 ? -mv : mv;
    spare_z = zv[31:0];
    spare_ok = 1;
    res.sample = scale_sample(zu);
    res.from_spare = 0;
    return 1;
  endfunction

  task automatic send_pair(logic [31:0] u, logic [31:0] v);
    sample_t r;
    if (!quiet) begin
      while ($urandom_range(3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_uniform_u <= u;
    in_uniform_v <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    if (polar_predict(u, v, r)) pending_q.push_back(r);
    in_valid <= 1'b0;
    // block is still busy right after accept
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [gpg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == gpg_pkg::REG_MEAN) mean_q = $signed({{32{d[31]}}, d});
    else if (idx == gpg_pkg::REG_STD) std_q = {32'd0, d};
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    sample_t x;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_seen++;
        if (pending_q.size() == 0) begin
          $display("%0t unexpected beat: expected none, actual %h/%b", $time,
                   out_sample, out_from_spare);
          errors++;
        end else begin
          x = pending_q.pop_front();
          if (x.from_spare) n_spare++;
          if (x.sample == 32'h7fffffff || x.sample == 32'h80000000) n_sat++;
          if (out_sample !== x.sample) begin
            $display("%0t sample: expected %h, actual %h", $time, x.sample, out_sample);
            errors++;
          end
          if (out_from_spare !== x.from_spare) begin
            $display("%0t from_spare: expected %b, actual %b", $time,
                     x.from_spare, out_from_spare);
            errors++;
          end
        end
      end
      out_stall <= !quiet && ($urandom_range(4) == 0);
    end
  end

  task automatic test_directed();
    logic [31:0] ex[6] = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h1,
                           32'hffffffff, 32'h40000000};
    foreach (ex[i]) send_pair(ex[i], ex[(i + 3) % 6]);
    send_pair(32'h0, 32'h0);           // zero pair rejected
    send_pair(32'h80000000, 32'h0);    // unit circle rejected
    send_pair(32'h5a827999, 32'h5a827999);
    send_pair(32'h00000001, 32'h00000000);
    send_pair(32'h10000000, 32'hf0000000);
    send_pair(32'h12345678, 32'h0);
    send_pair(32'h0, 32'h0);
  endtask

  task automatic test_config_sweep();
    write_reg(gpg_pkg::REG_MEAN, 32'h7fffffff);
    write_reg(gpg_pkg::REG_STD, 32'hffffffff);
    send_pair(32'h30000000, 32'hd0000000);
    send_pair(32'h0, 32'h0);
    write_reg(gpg_pkg::REG_MEAN, 32'h80000000);
    send_pair(32'hc0000000, 32'h00001000);
    send_pair(32'h0, 32'h0);
    write_reg(gpg_pkg::REG_STD, 32'h0);
    send_pair(32'h00000003, 32'h00000007);
    send_pair(32'h0, 32'h0);
    write_reg(REG_UNMAPPED, 32'hdeadbeef);
    write_reg(gpg_pkg::REG_STD, 32'h00010000);
    // spare scaled with register values at emit time
    send_pair(32'h20000000, 32'h20000000);
    write_reg(gpg_pkg::REG_MEAN, 32'h00050000);
    send_pair(32'h0, 32'h0);
    write_reg(gpg_pkg::REG_MEAN, 32'h0);
  endtask

  task automatic test_random(int n);
    logic [31:0] u, v;
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) begin
        write_reg(gpg_pkg::REG_MEAN, $urandom());
        write_reg(gpg_pkg::REG_STD, $urandom_range(32'h00200000));
      end
      if (i == n / 2) drain();
      if (i == n - 100) quiet = 1'b1;
      u = $urandom();
      v = $urandom();
      case ($urandom_range(9))
        0: begin u = u >>> $urandom_range(31); v = v >>> $urandom_range(31); end
        1: begin u = $urandom_range(1) ? 32'h80000000 : u; v = 32'h0; end
        2: ;
        default: begin u = $signed(u) >>> 1; v = $signed(v) >>> 1; end
      endcase
      send_pair(u, v);
    end
  endtask

  initial begin
    mean_q = $signed({32'd0, gpg_pkg::MEAN_RST});
    std_q = {32'd0, gpg_pkg::STD_RST};
    spare_ok = 0;
    spare_z = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_random(900);
    drain();
    $display("sent %0d pairs, checked %0d samples (%0d spare, %0d saturated)",
             n_sent, n_seen, n_spare, n_sat);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
